@@ rtl/core/eds_pkg.sv @@
// Shared types, constants and codes for the edit distance similarity block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package eds_pkg;

    // Longest string held, and the widths that follow from it.
    localparam int MAX_LEN = 32;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 5;
    localparam int THR_W   = 7;

    // Reset value of the similarity threshold.
    localparam logic [THR_W-1:0] THR_RESET = 7'd80;

    // Scale used by the score test.
    localparam logic signed [7:0] SCORE_SCALE = 8'sd99;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_FIRST  = 2'd1;
    localparam logic [1:0] CMD_SECOND = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    // Status codes on the result channel.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OVF  = 2'd1;
    localparam logic [1:0] STAT_LATE = 2'd2;

    // Data moving from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic [7:0]       ch;
        logic [LEN_W-1:0] left;   // new row value of the cell on the left
        logic [LEN_W-1:0] diag;   // old row value of the cell on the left
    } link_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic       clear;
        logic       load;
        logic [7:0] load_byte;
    } cell_ctrl_t;

    // One result item.
    typedef struct packed {
        logic             done_res;
        logic [1:0]       status;
        logic             similar;
        logic [LEN_W-1:0] distance;
    } result_t;

endpackage

@@ rtl/core/eds_cell.sv @@
// One cell of the Levenshtein row: holds one first-string byte and one row entry.
// Depends on eds_pkg for the link and control types.
`timescale 1ns / 1ps

module eds_cell
    import eds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic             load_sel,
    input  logic [LEN_W-1:0] init_val,
    input  link_t            link_in,
    output link_t            link_out,
    output logic [LEN_W-1:0] row_val,
    output logic             busy
);

    logic [7:0]       ch_reg;
    logic [LEN_W-1:0] row_reg, row_next;
    link_t            link_reg, link_next;
    logic [LEN_W-1:0] min_ul, min_all;

    // Edit step: match takes the diagonal, else one plus the smallest neighbor.
    always_comb begin
        min_ul  = (row_reg < link_in.left) ? row_reg : link_in.left;
        min_all = (min_ul < link_in.diag) ? min_ul : link_in.diag;
        if (ch_reg == link_in.ch) begin
            row_next = link_in.diag;
        end else begin
            row_next = min_all + LEN_W'(1);
        end
        link_next.valid = link_in.valid & ~ctrl.clear;
        link_next.ch    = link_in.ch;
        link_next.left  = row_next;
        link_next.diag  = row_reg;
    end

    // Row entry: back to its index on reset or clear.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            row_reg <= init_val;
        end else if (link_in.valid) begin
            row_reg <= row_next;
        end
    end

    // Only the valid bit of the forward link needs a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
        end else begin
            link_reg.valid <= link_next.valid;
        end
        link_reg.ch   <= link_next.ch;
        link_reg.left <= link_next.left;
        link_reg.diag <= link_next.diag;
    end

    // First-string byte for this position.
    always_ff @(posedge aclk) begin
        if (ctrl.load && load_sel) begin
            ch_reg <= ctrl.load_byte;
        end
    end

    assign link_out = link_reg;
    assign row_val  = row_reg;
    assign busy     = link_reg.valid;

endmodule

@@ rtl/core/eds_chain.sv @@
// Row of MAX_LEN cells; a second-string byte steps one cell to the right per cycle.
// Depends on eds_pkg and eds_cell.
`timescale 1ns / 1ps

module eds_chain
    import eds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic [LEN_W-1:0] load_idx,
    input  link_t            head,
    output logic [LEN_W-1:0] rows [MAX_LEN],
    output logic             busy
);

    link_t              links [MAX_LEN+1];
    logic [MAX_LEN-1:0] cell_busy;

    assign links[0] = head;

    // Cell k holds row entry k+1 and first-string byte k.
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        eds_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .load_sel (load_idx == LEN_W'(k)),
            .init_val (LEN_W'(k + 1)),
            .link_in  (links[k]),
            .link_out (links[k+1]),
            .row_val  (rows[k]),
            .busy     (cell_busy[k])
        );
    end

    // Any byte still in flight keeps the row from being read.
    assign busy = |cell_busy;

endmodule

@@ rtl/core/edit_distance_similarity.sv @@
// Top level of the edit distance similarity block: command decode, finish unit,
// result queue and configuration register. Depends on eds_pkg and eds_chain.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tuser: cmd[1:0]; tdata: char_byte[7:0]
//  m_*      | out       | tuser: done_res; tdata: distance, similar, status
//  cfg_*    | in        | cfg_data: similar_threshold[6:0]
//
//  Clear and append commands may follow back to back while the result queue has room;
//  a second-string byte walks the cell row at one cell per cycle.
//  Finish waits in the drain state until the row has drained, capturing the row entry,
//  then tests the score and queues the result in the calc state.
//  Results pass through a two-entry queue, so input is taken while one waits.
//  Reset is synchronous and active low; it returns the row to entry i = i.

module edit_distance_similarity
    import eds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] char_byte
    input  logic [1:0]       s_tuser,    // [1:0] cmd
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [5:0] distance, [6] similar, [8:7] status
    output logic             m_tuser,    // [0] done_res
    // Configuration write.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    localparam logic [1:0] FSM_IDLE  = 2'd0;
    localparam logic [1:0] FSM_DRAIN = 2'd1;
    localparam logic [1:0] FSM_CALC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [THR_W-1:0] thr_reg;
    logic [LEN_W-1:0] first_len_reg, second_len_reg;
    logic [LEN_W-1:0] dist_reg, maxlen_reg;
    logic             both_reg;

    logic             in_xfer, out_xfer;
    logic [1:0]       cmd;
    cell_ctrl_t       ctrl;
    link_t            head;
    logic [LEN_W-1:0] rows [MAX_LEN];
    logic             chain_busy;
    logic [LEN_W-1:0] row_sel;
    logic [LEN_W-1:0] row_idx;

    result_t          push_res;
    logic             push;
    result_t          q_mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    logic signed [15:0] lhs, rhs;
    logic               sim;

    assign cmd       = s_tuser;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign s_tready  = (state_reg == FSM_IDLE) && (count_reg != 2'd2);
    assign cfg_ready = 1'b1;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Command decode: chain control, head of the row and immediate results.
    always_comb begin
        ctrl.clear     = in_xfer && (cmd == CMD_CLEAR);
        ctrl.load      = 1'b0;
        ctrl.load_byte = s_tdata;
        head.valid     = 1'b0;
        head.ch        = s_tdata;
        head.diag      = second_len_reg;
        head.left      = second_len_reg + LEN_W'(1);
        push_res       = '0;
        push           = 1'b0;
        if (in_xfer) begin
            unique case (cmd)
                CMD_CLEAR: begin
                    push = 1'b1;
                end
                CMD_FIRST: begin
                    push = 1'b1;
                    if (second_len_reg != '0) begin
                        push_res.status = STAT_LATE;
                    end else if (first_len_reg >= LEN_W'(MAX_LEN)) begin
                        push_res.status = STAT_OVF;
                    end else begin
                        ctrl.load = 1'b1;
                    end
                end
                CMD_SECOND: begin
                    push = 1'b1;
                    if (second_len_reg >= LEN_W'(MAX_LEN)) begin
                        push_res.status = STAT_OVF;
                    end else begin
                        head.valid = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    push = 1'b0;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
        if (state_reg == FSM_CALC) begin
            push              = 1'b1;
            push_res.done_res = 1'b1;
            push_res.distance = dist_reg;
            push_res.similar  = sim;
        end
    end

    // String lengths.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
        end else begin
            if (ctrl.load) begin
                first_len_reg <= first_len_reg + LEN_W'(1);
            end
            if (head.valid) begin
                second_len_reg <= second_len_reg + LEN_W'(1);
            end
        end
    end

    eds_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .load_idx (first_len_reg),
        .head     (head),
        .rows     (rows),
        .busy     (chain_busy)
    );

    // Row entry at the first-string length; entry zero is the second length.
    assign row_idx = first_len_reg - LEN_W'(1);
    assign row_sel = (first_len_reg == '0) ? second_len_reg : rows[row_idx[IDX_W-1:0]];

    // Finish sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_xfer && (cmd == CMD_FINISH)) begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN: begin
                if (!chain_busy) begin
                    state_next = FSM_CALC;
                end
            end
            FSM_CALC: begin
                state_next = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture distance and longer length once the row is settled.
    always_ff @(posedge aclk) begin
        if (state_reg == FSM_DRAIN) begin
            dist_reg   <= row_sel;
            maxlen_reg <= (first_len_reg > second_len_reg) ? first_len_reg : second_len_reg;
            both_reg   <= (first_len_reg != '0) && (second_len_reg != '0);
        end
    end

    // Score test: 99*(m-d) >= (threshold-1)*m, in 16-bit signed integers.
    always_comb begin
        lhs = 16'(SCORE_SCALE) * ($signed({10'd0, maxlen_reg}) - $signed({10'd0, dist_reg}));
        rhs = ($signed({9'd0, thr_reg}) - 16'sd1) * $signed({10'd0, maxlen_reg});
        sim = both_reg && (lhs >= rhs);
    end

    // Two-entry result queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_xfer) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(out_xfer);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_res;
        end
    end

    // Result channel.
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tuser  = q_mem_reg[rd_ptr_reg].done_res;
    assign m_tdata  = {7'd0, q_mem_reg[rd_ptr_reg].status,
                       q_mem_reg[rd_ptr_reg].similar,
                       q_mem_reg[rd_ptr_reg].distance};

endmodule

@@ rtl/core/eds_checker.sv @@
// Port-level checks for the edit distance similarity block, bound to the top.
// Depends on eds_pkg and the top-level port list.
`timescale 1ns / 1ps

module eds_checker
    import eds_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [7:0]       s_tdata,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [15:0]      m_tdata,
    input logic             m_tuser,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [THR_W-1:0] cfg_data
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a finish transfer carries a distance or a similar flag.
    a_no_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[6:0] == 7'd0)
        else $error("distance on a non-finish result");

    // A finish transfer always reports ok status.
    a_fin_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[8:7] == STAT_OK)
        else $error("finish result with nonzero status");

    // The unused status code and padding never appear.
    a_stat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:7] != 2'b11 && m_tdata[15:9] == 7'd0)
        else $error("bad status or padding");

endmodule

bind edit_distance_similarity eds_checker u_eds_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for edit_distance_similarity: random and directed command streams
// against a scoreboard holding its own Levenshtein row. Depends on eds_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import eds_pkg::*;

    // Tracks the strings and the distance row, and queues the result each command should give.
    class distance_scoreboard;
        logic [7:0]       first_bytes[MAX_LEN];
        logic [LEN_W-1:0] row[MAX_LEN+1];
        logic [LEN_W-1:0] first_len;
        logic [LEN_W-1:0] second_len;
        logic [THR_W-1:0] threshold;
        result_t          expected_results[$];
        int               errors;

        function new();
            threshold = THR_RESET;
            errors = 0;
            clear_strings();
        endfunction

        function void clear_strings();
            for (int i = 0; i <= MAX_LEN; i++) begin
                row[i] = LEN_W'(i);
            end
            first_len = '0;
            second_len = '0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        // Applies one accepted command and queues its result.
        function void note_command(logic [1:0] cmd, logic [7:0] ch);
            result_t          res;
            logic [LEN_W-1:0] diag, left, up, best, next;
            logic [LEN_W-1:0] longer;
            int               lhs, rhs;
            res = '0;
            case (cmd)
                CMD_CLEAR: begin
                    clear_strings();
                end
                CMD_FIRST: begin
                    // A first-string byte after the second string has begun is rejected with late status.
                    if (second_len != 0) begin
                        res.status = STAT_LATE;
                    end else if (first_len >= MAX_LEN) begin
                        res.status = STAT_OVF;
                    end else begin
                        first_bytes[first_len] = ch;
                        first_len++;
                    end
                end
                CMD_SECOND: begin
                    if (second_len >= MAX_LEN) begin
                        res.status = STAT_OVF;
                    end else begin
                        // One Levenshtein row update for the new second-string byte.
                        diag = row[0];
                        second_len++;
                        row[0] = second_len;
                        left = row[0];
                        for (int i = 1; i <= int'(first_len); i++) begin
                            up = row[i];
                            if (first_bytes[i-1] == ch) begin
                                next = diag;
                            end else begin
                                best = up;
                                if (left < best) best = left;
                                if (diag < best) best = diag;
                                next = best + 1'b1;
                            end
                            row[i] = next;
                            diag = up;
                            left = next;
                        end
                    end
                end
                default: begin
                    res.done_res = 1'b1;
                    res.distance = row[first_len];
                    longer = (first_len > second_len) ? first_len : second_len;
                    // The score test in integers; an empty string is never similar.
                    if (first_len != 0 && second_len != 0) begin
                        lhs = int'(SCORE_SCALE) * (int'(longer) - int'(res.distance));
                        rhs = (int'(threshold) - 1) * int'(longer);
                        res.similar = (lhs >= rhs);
                    end
                end
            endcase
            expected_results.insert(expected_results.size(), res);
        endfunction

        // Compares one result transfer with the oldest queued expectation.
        function void check_result(logic done_bit, logic [15:0] data);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation pending: tuser=%0b tdata=%h",
                       done_bit, data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (done_bit !== want.done_res) begin
                $error("done_res: expected %0d, got %0d", want.done_res, done_bit);
                errors++;
            end
            if (data[5:0] !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, data[5:0]);
                errors++;
            end
            if (data[6] !== want.similar) begin
                $error("similar: expected %0d, got %0d", want.similar, data[6]);
                errors++;
            end
            if (data[8:7] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, data[8:7]);
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;     // [7:0] char_byte
    logic [1:0]       s_tuser = '0;     // [1:0] cmd
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;          // [5:0] distance, [6] similar, [8:7] status
    logic             m_tuser;          // [0] done_res
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;

    distance_scoreboard sb = new();
    int                 burst_left = 0;

    edit_distance_similarity dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop for a hung run.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Every transfer on every channel is sampled here, at the edge where it happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_threshold(cfg_data);
            if (s_tvalid && s_tready) sb.note_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
    end

    // Receiver backpressure: switches between free flow, random stalls and long stalls.
    int ready_mode = 0;
    int mode_left = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : 0;
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Sends one command; the sender runs in bursts with random gaps between them.
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops sending and waits until every expected result is back, then lets the row drain.
    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        burst_left = 0;
        waited = 0;
        // Wait for a clock edge first, so the last accepted command is already in the scoreboard.
        @(posedge aclk);
        while (sb.expected_results.size() != 0 && waited < 50_000) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.errors++;
            sb.expected_results.delete();
        end
        repeat (MAX_LEN + 8) @(posedge aclk);
    endtask

    // Mostly short strings, sometimes long enough to overflow.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return $urandom_range(0, 10);
        if (r == 8) return $urandom_range(11, 31);
        return $urandom_range(30, MAX_LEN + 2);
    endfunction

    function automatic logic [7:0] pick_byte(input bit wide_bytes);
        if (wide_bytes) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    // Mostly complete clear/load/compare/finish sequences, with some stray commands.
    task automatic run_random_phase(input int count);
        int         sent, nf, ns, reps;
        bit         wide_bytes;
        logic [7:0] first_copy[MAX_LEN+4];
        logic [7:0] ch;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                wide_bytes = ($urandom_range(0, 4) == 0);
                nf = pick_length();
                ns = pick_length();
                send_command(CMD_CLEAR, 8'($urandom));
                for (int k = 0; k < nf; k++) begin
                    ch = pick_byte(wide_bytes);
                    first_copy[k] = ch;
                    send_command(CMD_FIRST, ch);
                end
                // The second string is usually a mutated copy of the first.
                for (int k = 0; k < ns; k++) begin
                    if (k < nf && $urandom_range(0, 3) != 0) ch = first_copy[k];
                    else ch = pick_byte(wide_bytes);
                    send_command(CMD_SECOND, ch);
                end
                if (ns > 0 && $urandom_range(0, 7) == 0) begin
                    send_command(CMD_FIRST, 8'($urandom));
                    sent++;
                end
                reps = $urandom_range(1, 2);
                repeat (reps) send_command(CMD_FINISH, 8'($urandom));
                sent += 1 + nf + ns + reps;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_command(2'($urandom_range(0, 3)), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    logic [THR_W-1:0] phase_thresholds[8];

    initial begin
        phase_thresholds = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd2, 7'd99, 7'd50, 7'd80};
        phase_thresholds[7] = 7'($urandom_range(1, 100));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset threshold: empty strings, byte extremes,
        // a late first-string byte, repeated finish and an exact match.
        send_command(CMD_CLEAR, 8'h00);
        send_command(CMD_FINISH, 8'hFF);
        send_command(CMD_FIRST, 8'h00);
        send_command(CMD_FINISH, 8'h00);
        send_command(CMD_SECOND, 8'hFF);
        send_command(CMD_FINISH, 8'h00);
        send_command(CMD_SECOND, 8'h00);
        send_command(CMD_FINISH, 8'h00);
        send_command(CMD_FIRST, 8'hAA);
        send_command(CMD_FINISH, 8'h55);
        send_command(CMD_FINISH, 8'hAA);
        send_command(CMD_CLEAR, 8'hFF);
        send_command(CMD_FIRST, 8'h61);
        send_command(CMD_FIRST, 8'h62);
        send_command(CMD_FIRST, 8'h63);
        send_command(CMD_SECOND, 8'h61);
        send_command(CMD_SECOND, 8'h62);
        send_command(CMD_SECOND, 8'h63);
        send_command(CMD_FINISH, 8'h00);
        send_command(CMD_SECOND, 8'h78);
        send_command(CMD_FINISH, 8'h00);
        send_command(CMD_CLEAR, 8'h00);
        send_command(CMD_SECOND, 8'h71);
        send_command(CMD_FINISH, 8'h00);
        drain_results();

        // Random phases, each under its own threshold, written only while idle.
        foreach (phase_thresholds[p]) begin
            cfg_valid <= 1'b1;
            cfg_data <= phase_thresholds[p];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_valid <= 1'b0;
            run_random_phase(90);
            drain_results();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
